>>> rtl/core/jovf_pkg.sv
// shared types, character codes and helpers for the json int64 overflow scanner
package jovf_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned MAG_W           = 64;
  localparam int unsigned RES_OFF_W       = 32;
  localparam int unsigned OUT_TDATA_W     = 40;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_RBRC  = 8'h7d;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  // one document byte
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } item_t;

  // one scan result
  typedef struct packed {
    logic [RES_OFF_W-1:0] offset;
    logic                 found;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_COMMA, CH_RBRK, CH_RBRC};
  endfunction

  // integer literal whose magnitude is out of signed 64-bit range
  function automatic logic tok_overflows(input logic has_digit, input logic all_digits,
                                         input logic negative, input logic [MAG_W-1:0] mag);
    return has_digit && all_digits && mag[MAG_W-1] && (!negative || (|mag[MAG_W-2:0]));
  endfunction

endpackage

>>> rtl/core/jovf_in_stage.sv
// input register for document bytes
module jovf_in_stage
  import jovf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_take
);

  logic  v_r;
  item_t item_r;

  assign in_ready = !v_r || q_take;
  assign q_valid  = v_r;
  assign q_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

>>> rtl/core/jovf_scan_core.sv
// lexer state, saturating magnitude and first-overflow tracking
module jovf_scan_core
  import jovf_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_take,
  input  logic    res_ready,
  output logic    res_valid,
  output result_t res
);

  logic                   in_str_r, in_str_nxt;
  logic                   esc_r, esc_nxt;
  logic                   in_tok_r, in_tok_nxt;
  logic                   neg_r, neg_nxt;
  logic                   all_r, all_nxt;
  logic                   has_r, has_nxt;
  logic [MAG_W-1:0]       mag_r, mag_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic                   hit_v_r, hit_v_nxt;
  logic [OFFSET_BITS-1:0] hit_off_r, hit_off_nxt;

  logic [7:0]             c;
  logic                   c_digit;
  logic [MAG_W+3:0]       mag_x10;
  logic [MAG_W-1:0]       mag_add;
  logic                   term_case;
  logic                   finish_now;
  logic [RES_OFF_W-1:0]   off_res;

  assign c       = q_item.data;
  assign c_digit = is_digit(c);
  assign q_take  = q_valid && (!q_item.last || res_ready);

  // mag*10 + digit, saturating when it spills past 64 bits
  assign mag_x10 = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1)
                   + {{(MAG_W){1'b0}}, c[3:0]};
  assign mag_add = (|mag_x10[MAG_W+3:MAG_W]) ? {MAG_W{1'b1}} : mag_x10[MAG_W-1:0];

  always_comb begin
    in_str_nxt = in_str_r;
    esc_nxt    = esc_r;
    in_tok_nxt = in_tok_r;
    neg_nxt    = neg_r;
    all_nxt    = all_r;
    has_nxt    = has_r;
    mag_nxt    = mag_r;
    start_nxt  = start_r;
    term_case  = 1'b0;
    if (in_str_r) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (c == CH_BSL) begin
        esc_nxt = 1'b1;
      end else if (c == CH_QUOTE) begin
        in_str_nxt = 1'b0;
      end
    end else if (in_tok_r) begin
      if (is_term(c)) begin
        term_case  = 1'b1;
        in_tok_nxt = 1'b0;
      end else if (c_digit && all_r) begin
        mag_nxt = mag_add;
        has_nxt = 1'b1;
      end else begin
        all_nxt = 1'b0;
      end
    end else if (c == CH_QUOTE) begin
      in_str_nxt = 1'b1;
      esc_nxt    = 1'b0;
    end else if ((c == CH_MINUS) || c_digit) begin
      in_tok_nxt = 1'b1;
      start_nxt  = pos_r;
      all_nxt    = 1'b1;
      neg_nxt    = (c == CH_MINUS);
      has_nxt    = c_digit;
      mag_nxt    = c_digit ? {{(MAG_W-4){1'b0}}, c[3:0]} : '0;
    end
  end

  // a token ends on a terminator, or with the document
  assign finish_now  = term_case || (q_item.last && in_tok_nxt);
  assign hit_v_nxt   = hit_v_r ||
                       (finish_now && tok_overflows(has_nxt, all_nxt, neg_nxt, mag_nxt));
  assign hit_off_nxt = hit_v_r ? hit_off_r : start_nxt;
  assign pos_nxt     = pos_r + 1'b1;

  generate
    if (OFFSET_BITS >= RES_OFF_W) begin : g_off_trunc
      assign off_res = hit_off_nxt[RES_OFF_W-1:0];
    end else begin : g_off_ext
      assign off_res = {{(RES_OFF_W-OFFSET_BITS){1'b0}}, hit_off_nxt};
    end
  endgenerate

  assign res_valid  = q_take && q_item.last;
  assign res.found  = hit_v_nxt;
  assign res.offset = hit_v_nxt ? off_res : '0;

  always_ff @(posedge clk) begin
    if (!rst_n || (q_take && q_item.last)) begin
      in_str_r  <= 1'b0;
      esc_r     <= 1'b0;
      in_tok_r  <= 1'b0;
      neg_r     <= 1'b0;
      all_r     <= 1'b0;
      has_r     <= 1'b0;
      mag_r     <= '0;
      start_r   <= '0;
      pos_r     <= '0;
      hit_v_r   <= 1'b0;
      hit_off_r <= '0;
    end else if (q_take) begin
      in_str_r  <= in_str_nxt;
      esc_r     <= esc_nxt;
      in_tok_r  <= in_tok_nxt;
      neg_r     <= neg_nxt;
      all_r     <= all_nxt;
      has_r     <= has_nxt;
      mag_r     <= mag_nxt;
      start_r   <= start_nxt;
      pos_r     <= pos_nxt;
      hit_v_r   <= hit_v_nxt;
      hit_off_r <= hit_off_nxt;
    end
  end

endmodule

>>> rtl/core/jovf_out_stage.sv
// result register toward the output channel
module jovf_out_stage
  import jovf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res,
  output logic    res_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    v_r;
  result_t res_r;

  assign res_ready = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (res_ready) begin
      v_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

endmodule

>>> rtl/core/json_int64_overflow_scanner_top.sv
// top level of the json int64 overflow scanner
//
// Scans a JSON document streamed one byte per item (tlast on the final byte) and reports
// whether any integer literal falls outside the signed 64-bit range, with the byte offset
// where the first such literal starts. Outside strings a token starts at '-' or a digit and
// runs until whitespace, ',', ']', '}' or the document end; inside strings a backslash
// skips the next byte. Exactly one result item is sent per document, carrying the found
// flag and the offset (zero when nothing overflowed); all scan state clears after it.
// Throughput is one byte per clock cycle with no gaps between documents, except while
// the input stalls as described below. Each byte is first captured in an input register
// and is then scanned from it, where the saturating multiply-by-ten-and-add on the 64-bit
// magnitude is the critical path; when the last byte is scanned, the result is registered
// in the output register, which drives out_tvalid. The input side stalls only when a
// finished result is still held and out_tready is low while the next byte to scan is a
// last byte. Offsets count from zero and wrap at OFFSET_BITS.
module json_int64_overflow_scanner_top
  import jovf_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // last_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [0] overflow_found, [32:1] overflow_offset
);

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_take;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;

  assign in_item.data = in_tdata;
  assign in_item.last = in_tlast;

  // byte capture
  jovf_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take)
  );

  // lexer and overflow detection, one byte a cycle unless a last byte waits on the result
  jovf_scan_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // result holding register
  jovf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // pad the packed result up to whole bytes
  assign out_tdata = {{(OUT_TDATA_W-RES_OFF_W-1){1'b0}}, out_res.offset, out_res.found};

`ifndef ASSERT_OFF
  // a fresh result only follows a scanned last byte
  a_res_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(q_take && q_item.last))
    else $error("result without a last byte");

  // no hit means a zero offset
  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[RES_OFF_W:1] == '0))
    else $error("nonzero offset without overflow");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready && q_valid && q_item.last))
    else $error("input stalled without a blocked result");

  // a captured byte that is not taken stays put
  a_q_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !q_take) |=> (q_valid && $stable(q_item)))
    else $error("pending byte lost");
`endif

endmodule

>>> tb/json_scan_checker.sv
// checker for the json int64 overflow scanner: tracks the byte stream and compares results
`timescale 1ns / 100ps

module json_scan_checker
  import jovf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int unsigned            mismatches,
  output int unsigned            pending
);

  localparam logic [MAG_W-1:0] MAG_MAX   = '1;
  localparam logic [MAG_W-1:0] POS_BOUND = 64'h7fff_ffff_ffff_ffff;
  localparam logic [MAG_W-1:0] NEG_BOUND = 64'h8000_0000_0000_0000;

  // scan state
  logic                 in_str;
  logic                 esc_next;
  logic                 in_tok;
  logic                 tok_neg;
  logic                 tok_digits_only;
  logic                 tok_seen_digit;
  logic [MAG_W-1:0]     tok_mag;
  logic [RES_OFF_W-1:0] tok_start;
  logic [RES_OFF_W-1:0] byte_pos;
  logic                 hit_seen;
  logic [RES_OFF_W-1:0] hit_offset;

  result_t verdict_q[$];

  function automatic logic digit_char(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic clear_scan();
    in_str          = 1'b0;
    esc_next        = 1'b0;
    in_tok          = 1'b0;
    tok_neg         = 1'b0;
    tok_digits_only = 1'b0;
    tok_seen_digit  = 1'b0;
    tok_mag         = '0;
    tok_start       = '0;
    byte_pos        = '0;
    hit_seen        = 1'b0;
    hit_offset      = '0;
  endtask

  // saturating magnitude = magnitude * 10 + digit
  task automatic push_digit(input logic [7:0] c);
    logic [MAG_W-1:0] d;
    d = MAG_W'(c - CH_ZERO);
    if (tok_mag > (MAG_MAX - d) / 10) tok_mag = MAG_MAX;
    else tok_mag = tok_mag * 10 + d;
    tok_seen_digit = 1'b1;
  endtask

  task automatic close_token();
    if (tok_seen_digit && tok_digits_only && !hit_seen &&
        tok_mag > (tok_neg ? NEG_BOUND : POS_BOUND)) begin
      hit_seen   = 1'b1;
      hit_offset = tok_start;
    end
    in_tok = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic last);
    result_t r;
    if (in_str) begin
      if (esc_next) esc_next = 1'b0;
      else if (c == CH_BSL) esc_next = 1'b1;
      else if (c == CH_QUOTE) in_str = 1'b0;
    end else if (in_tok) begin
      if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_COMMA, CH_RBRK, CH_RBRC}) begin
        close_token();
      end else if (digit_char(c) && tok_digits_only) begin
        push_digit(c);
      end else begin
        tok_digits_only = 1'b0;
      end
    end else if (c == CH_QUOTE) begin
      in_str   = 1'b1;
      esc_next = 1'b0;
    end else if (c == CH_MINUS || digit_char(c)) begin
      in_tok          = 1'b1;
      tok_start       = byte_pos;
      tok_mag         = '0;
      tok_seen_digit  = 1'b0;
      tok_digits_only = 1'b1;
      tok_neg         = (c == CH_MINUS);
      if (!tok_neg) push_digit(c);
    end
    byte_pos = byte_pos + 1'b1;
    if (last) begin
      if (in_tok) close_token();
      r.found  = hit_seen;
      r.offset = hit_seen ? hit_offset : '0;
      verdict_q = {verdict_q, r};
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      clear_scan();
      verdict_q.delete();
    end else begin
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got = out_tdata[RES_OFF_W:0];
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: found=%0b offset=%0d", got.found, got.offset);
        end else begin
          want = verdict_q.pop_front();
          if (got.found !== want.found || got.offset !== want.offset) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                       want.found, want.offset, got.found, got.offset);
          end
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

>>> tb/tb_top.sv
// testbench top for the json int64 overflow scanner: document stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
  import jovf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = '0;   // [7:0] data_byte
  logic                   in_tlast   = 1'b0; // last_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [0] overflow_found, [32:1] overflow_offset

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // bytes of the document being built
  logic [7:0]  doc_bytes[$];
  int unsigned bytes_sent = 0;
  int unsigned docs_sent  = 0;
  bit          burst_mode = 1'b0;

  // long receiver hold-off, requested once by the stimulus
  bit          holdoff_req   = 1'b0;
  bit          holdoff_taken = 1'b0;
  int unsigned holdoff_left  = 0;
  int unsigned stall_left    = 0;

  always #5 clk = ~clk;

  json_int64_overflow_scanner_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  json_scan_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("** json_int64_overflow_scanner_top: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls, mostly short, plus one long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (holdoff_req && !holdoff_taken) begin
        holdoff_taken = 1'b1;
        holdoff_left  = 400;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
        out_tready <= 1'b1;
      end else begin
        // start a stall here, continued while stall_left counts down
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 2);
        out_tready <= 1'b0;
      end
    end
  end

  // append one byte to the document
  task automatic add_byte(input logic [7:0] b);
    doc_bytes = {doc_bytes, b};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // send the built document, tlast on its final byte, with random gaps between items unless in burst mode
  task automatic send_doc();
    int unsigned gap;
    for (int i = 0; i < doc_bytes.size(); i++) begin
      in_tvalid <= 1'b1;
      in_tdata  <= doc_bytes[i];
      in_tlast  <= (i == doc_bytes.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      bytes_sent++;
      if (!burst_mode && $urandom_range(0, 9) >= 6) begin
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    doc_bytes.delete();
    docs_sent++;
  endtask

  task automatic add_digits(input int unsigned n, input bit lead_nonzero);
    for (int i = 0; i < n; i++)
      add_byte(8'(CH_ZERO + ((i == 0 && lead_nonzero) ? $urandom_range(1, 9)
                                                      : $urandom_range(0, 9))));
  endtask

  // one json fragment, usually followed by a terminator when allowed
  task automatic add_piece(input bit allow_term);
    logic [7:0] terms[7];
    terms = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_COMMA, CH_RBRK, CH_RBRC};
    case ($urandom_range(0, 10))
      0, 1, 2: begin
        // literals right around the signed 64-bit limits and the saturation point
        case ($urandom_range(0, 10))
          0:  add_text("9223372036854775807");
          1:  add_text("9223372036854775808");
          2:  add_text("-9223372036854775808");
          3:  add_text("-9223372036854775809");
          4:  add_text("18446744073709551615");
          5:  add_text("18446744073709551616");
          6:  add_text("99999999999999999999999");
          7:  add_text("-00009223372036854775808");
          8:  add_text("-0");
          9:  add_text("0");
          default: begin
            if ($urandom_range(0, 1)) add_byte(CH_MINUS);
            add_text("92233720368547758");
            add_digits(2, 1'b0);
          end
        endcase
      end
      3, 4: begin
        if ($urandom_range(0, 2) == 0) add_byte(CH_MINUS);
        add_digits($urandom_range(1, 4), 1'b0);
      end
      5: begin
        // long digit run, often past the limit
        if ($urandom_range(0, 1)) add_byte(CH_MINUS);
        add_digits($urandom_range(17, 24), $urandom_range(0, 3) != 0);
      end
      6: begin
        // string with escapes; digits inside must be ignored
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 4))
            0: begin
              add_byte(CH_BSL);
              add_byte(8'($urandom_range(0, 255)));
            end
            1: add_digits($urandom_range(1, 21), 1'b1);
            2: add_byte(terms[$urandom_range(0, 6)]);
            3: add_byte(CH_MINUS);
            default: add_byte(8'($urandom_range(8'h61, 8'h7a)));
          endcase
        end
        // an unterminated string now and then
        if ($urandom_range(0, 9) != 0) add_byte(CH_QUOTE);
      end
      7: begin
        // malformed token: stray minus, quote, exponent or point inside
        add_digits($urandom_range(1, 20), 1'b1);
        case ($urandom_range(0, 3))
          0: add_byte(CH_MINUS);
          1: add_byte(CH_QUOTE);
          2: add_text("e");
          default: add_text(".");
        endcase
        add_digits($urandom_range(0, 20), 1'b0);
      end
      8: add_byte(CH_MINUS);
      9: repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
      default: begin
        case ($urandom_range(0, 4))
          0: add_text("[");
          1: add_text("{");
          2: add_text(":");
          3: add_text("true");
          default: add_text("null");
        endcase
      end
    endcase
    if (allow_term && $urandom_range(0, 9) < 8) add_byte(terms[$urandom_range(0, 6)]);
  endtask

  initial begin
    int unsigned n_pieces;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed documents
    add_text("7");                    // token ended by the end of the document
    send_doc();
    add_text("-");                    // lone minus
    send_doc();
    add_byte(CH_QUOTE);               // backslash as the very last byte
    add_byte(CH_BSL);
    send_doc();
    add_text("1");                    // quote inside a token opens no string
    add_byte(CH_QUOTE);
    add_text("2 ");
    send_doc();
    add_text("1-2,-");                // misplaced minus, then lone minus at the end
    send_doc();
    add_byte(CH_QUOTE);               // escaped quote keeps the string open
    add_byte(CH_BSL);
    add_byte(CH_QUOTE);
    add_text("9");
    send_doc();
    add_byte(8'h00);                  // byte extremes
    add_byte(8'hff);
    add_byte(CH_RBRC);
    send_doc();
    add_text("-0]");
    send_doc();

    // random documents; one burst runs against the long receiver hold-off
    while (bytes_sent < 400) begin
      burst_mode = (docs_sent >= 10 && docs_sent < 16) || ($urandom_range(0, 7) == 0);
      if (docs_sent == 10) holdoff_req = 1'b1;
      n_pieces = $urandom_range(1, 4);
      for (int p = 0; p < n_pieces; p++) add_piece(p != n_pieces - 1 || $urandom_range(0, 1));
      send_doc();
    end
    if (in_tvalid) in_tvalid <= 1'b0;

    // drain and let the pipeline settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("** json_int64_overflow_scanner_top: PASSED **");
    end else begin
      $display("** json_int64_overflow_scanner_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> json_int64_overflow_scanner_top.f
rtl/core/jovf_pkg.sv
rtl/core/jovf_in_stage.sv
rtl/core/jovf_scan_core.sv
rtl/core/jovf_out_stage.sv
rtl/core/json_int64_overflow_scanner_top.sv
tb/json_scan_checker.sv
tb/tb_top.sv
